// File: rtl/rbtd_pkg.sv
// Shared types, constants and helper functions for the RTC BCD time decode cache.
package rbtd_pkg;

    localparam int unsigned POLL_W    = 24;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DAYS_W    = 17;
    localparam int unsigned TOD_W     = 17;
    localparam int unsigned YOFF_W    = 8;

    localparam logic [11:0]        YEAR_BASE        = 12'd2024;
    localparam logic [11:0]        YEAR_1900        = 12'd1900;
    localparam logic [11:0]        YEAR_2000        = 12'd2000;
    localparam logic [POLL_W-1:0]  POLL_RESET       = 24'd1000;
    // days from 1970-01-01 to 2000-03-01
    localparam logic [DAYS_W-1:0]  DAYS_TO_2000_MAR = 17'd11017;
    localparam logic [7:0]         CENTURY_K        = 8'd100;
    localparam logic [33:0]        SECS_PER_DAY     = 34'd86400;

    // register map index (paddr[2])
    typedef enum logic {
        REG_DEVICE_PRESENT = 1'b0,
        REG_POLL_INTERVAL  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              device_present;
        logic [POLL_W-1:0] poll_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } clock_time_t;

    typedef struct packed {
        logic        ok;
        logic        from_cache;
        clock_time_t tm;
    } read_result_t;

    // packed BCD pair decoded arithmetically: hi*10 + lo, no digit check
    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
    endfunction

    // day of year at the start of each month, year starting in March
    function automatic logic [8:0] march_doy(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/rbtd_decode.sv
// BCD register decode and range check for one clock read.
module rbtd_decode (
    input  logic [7:0]           raw_seconds,
    input  logic [7:0]           raw_minutes,
    input  logic [7:0]           raw_hours,
    input  logic [7:0]           raw_date,
    input  logic [7:0]           raw_month,
    input  logic [7:0]           raw_year,
    output rbtd_pkg::clock_time_t tm,
    output logic                 valid_time
);

    logic [7:0]  sec_v;
    logic [7:0]  min_v;
    logic [7:0]  h12_raw;
    logic [7:0]  h12;
    logic [7:0]  hour_v;
    logic [7:0]  day_v;
    logic [7:0]  mon_v;
    logic [11:0] year_v;

    always_comb
    begin
        sec_v   = rbtd_pkg::bcd_val(raw_seconds & 8'h7F);
        min_v   = rbtd_pkg::bcd_val(raw_minutes & 8'h7F);
        h12_raw = rbtd_pkg::bcd_val(raw_hours & 8'h1F);
        h12     = (h12_raw == 8'd12) ? 8'd0 : h12_raw;
        if (raw_hours[6])
        begin
            hour_v = raw_hours[5] ? h12 + 8'd12 : h12;
        end
        else
        begin
            hour_v = rbtd_pkg::bcd_val(raw_hours & 8'h3F);
        end
        day_v  = rbtd_pkg::bcd_val(raw_date & 8'h3F);
        mon_v  = rbtd_pkg::bcd_val(raw_month & 8'h7F);
        year_v = (raw_month[7] ? rbtd_pkg::YEAR_1900 : rbtd_pkg::YEAR_2000)
               + {4'b0, rbtd_pkg::bcd_val(raw_year)};

        valid_time = (year_v >= rbtd_pkg::YEAR_BASE)
                   && (mon_v >= 8'd1) && (mon_v <= 8'd12)
                   && (day_v >= 8'd1) && (day_v <= 8'd31)
                   && (hour_v <= 8'd23) && (min_v <= 8'd59) && (sec_v <= 8'd59);

        tm.year   = year_v;
        tm.month  = mon_v[3:0];
        tm.day    = day_v[4:0];
        tm.hour   = hour_v[4:0];
        tm.minute = min_v[5:0];
        tm.second = sec_v[5:0];
    end

endmodule

// File: rtl/rbtd_epoch.sv
// Two-stage Unix epoch calculation: day count, then day count times seconds per day.
module rbtd_epoch (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  rbtd_pkg::read_result_t in_res,
    output logic                   out_valid,
    output rbtd_pkg::read_result_t out_res,
    output logic [31:0]            out_epoch
);

    logic                                 s2_valid_reg;
    rbtd_pkg::read_result_t               s2_res_reg;
    logic [rbtd_pkg::DAYS_W-1:0]          days_reg;
    logic [rbtd_pkg::DAYS_W-1:0]          days_next;
    logic [rbtd_pkg::TOD_W-1:0]           tod_reg;
    logic [rbtd_pkg::TOD_W-1:0]           tod_next;

    logic                                 s3_valid_reg;
    rbtd_pkg::read_result_t               s3_res_reg;
    logic [31:0]                          epoch_reg;
    logic [31:0]                          epoch_next;

    logic [11:0] yp;
    logic [3:0]  mp;
    logic [11:0] k_full;
    logic [7:0]  k;

    // March-based year so the leap day falls at the end
    always_comb
    begin
        if (in_res.tm.month <= 4'd2)
        begin
            yp = in_res.tm.year - 12'd1;
            mp = in_res.tm.month + 4'd9;
        end
        else
        begin
            yp = in_res.tm.year;
            mp = in_res.tm.month - 4'd3;
        end
        k_full = yp - rbtd_pkg::YEAR_2000;
        k      = k_full[7:0];
        // 2100 is the only century year in range
        days_next = rbtd_pkg::DAYS_TO_2000_MAR
                  + {9'b0, k} * 17'd365
                  + {11'b0, k[7:2]}
                  - ((k >= rbtd_pkg::CENTURY_K) ? 17'd1 : 17'd0)
                  + {8'b0, rbtd_pkg::march_doy(mp)}
                  + {12'b0, in_res.tm.day}
                  - 17'd1;
        tod_next = {12'b0, in_res.tm.hour} * 17'd3600
                 + {11'b0, in_res.tm.minute} * 17'd60
                 + {11'b0, in_res.tm.second};
    end

    always_comb
    begin
        if (s2_res_reg.ok)
        begin
            epoch_next = 32'(34'(days_reg) * rbtd_pkg::SECS_PER_DAY) + 32'(tod_reg);
        end
        else
        begin
            epoch_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_res_reg <= in_res;
            days_reg   <= days_next;
            tod_reg    <= tod_next;
            s3_res_reg <= s2_res_reg;
            epoch_reg  <= epoch_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_res   = s3_res_reg;
    assign out_epoch = epoch_reg;

endmodule

// File: rtl/rbtd_apb_regs.sv
// APB configuration registers: device present flag and poll interval.
module rbtd_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbtd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rbtd_pkg::DATA_W-1:0]   pwdata,
    output logic [rbtd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rbtd_pkg::cfg_t                cfg
);

    logic                          dev_reg;
    logic                          dev_next;
    logic [rbtd_pkg::POLL_W-1:0]   poll_reg;
    logic [rbtd_pkg::POLL_W-1:0]   poll_next;
    logic                          wr_en;
    rbtd_pkg::reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = rbtd_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        dev_next  = dev_reg;
        poll_next = poll_reg;
        if (wr_en)
        begin
            unique case (idx)
                rbtd_pkg::REG_DEVICE_PRESENT: dev_next  = pwdata[0];
                rbtd_pkg::REG_POLL_INTERVAL:  poll_next = pwdata[rbtd_pkg::POLL_W-1:0];
                default:                      dev_next  = dev_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rbtd_pkg::REG_DEVICE_PRESENT: prdata = {31'b0, dev_reg};
            rbtd_pkg::REG_POLL_INTERVAL:  prdata = {8'b0, poll_reg};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg  <= 1'b0;
            poll_reg <= rbtd_pkg::POLL_RESET;
        end
        else
        begin
            dev_reg  <= dev_next;
            poll_reg <= poll_next;
        end
    end

    assign cfg.device_present   = dev_reg;
    assign cfg.poll_interval_ms = poll_reg;

endmodule

// File: rtl/rtc_bcd_time_decode_cache_unit.sv
// Top level of the RTC BCD time decode cache.
//
// Each request is one read of the clock chip's six time registers plus a
// millisecond timestamp. The block decodes the BCD bytes, checks the ranges,
// decides between the fresh read and the one-entry cache, and returns one
// result per request with Unix epoch seconds. It takes a new request every
// clock cycle while out_ready is high; a request's result passes in turn
// through the input register (loaded at the edge that accepts it), the
// decode/cache decision register, the day count register and the epoch
// register. The longest path is the 17x17-bit day count times 86400 in the
// last stage. All stages advance together; when the output register is full
// and out_ready is low, in_ready drops. The cache decision and the cache
// update happen in the same stage, so a request always sees the cache as left
// by every request accepted before it. Cached time fields have no reset and
// are only read once a good read has set the cache valid flag. pready is tied
// high. The user writes configuration (device_present at byte address 0,
// poll_interval_ms at 4) over APB only while the block is idle; not enforced.
module rtc_bcd_time_decode_cache_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbtd_pkg::ADDR_W-1:0]   paddr,
    input  logic [rbtd_pkg::DATA_W-1:0]   pwdata,
    output logic [rbtd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // request
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   now_ms,
    input  logic                          force_refresh,
    input  logic                          bus_ok,
    input  logic [7:0]                    raw_seconds,
    input  logic [7:0]                    raw_minutes,
    input  logic [7:0]                    raw_hours,
    input  logic [7:0]                    raw_date,
    input  logic [7:0]                    raw_month,
    input  logic [7:0]                    raw_year,
    // result
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          read_ok,
    output logic                          from_cache,
    output logic [5:0]                    second,
    output logic [5:0]                    minute,
    output logic [4:0]                    hour,
    output logic [4:0]                    day,
    output logic [3:0]                    month,
    output logic [11:0]                   year,
    output logic [31:0]                   epoch_seconds
);

    rbtd_pkg::cfg_t cfg;

    // pipeline advance: everything moves when the output slot is free or drains
    logic adv;

    // input register
    logic        s0_valid_reg;
    logic [31:0] s0_now_reg;
    logic        s0_force_reg;
    logic        s0_bus_reg;
    logic [7:0]  s0_sec_reg;
    logic [7:0]  s0_min_reg;
    logic [7:0]  s0_hour_reg;
    logic [7:0]  s0_date_reg;
    logic [7:0]  s0_month_reg;
    logic [7:0]  s0_year_reg;

    // decision result register
    logic                   s1_valid_reg;
    rbtd_pkg::read_result_t s1_res_reg;
    rbtd_pkg::read_result_t s1_res_next;

    // one-entry cache
    logic                               cache_valid_reg;
    logic                               cache_valid_next;
    logic [31:0]                        last_poll_reg;
    logic [31:0]                        last_poll_next;
    logic [5:0]                         c_sec_reg;
    logic [5:0]                         c_min_reg;
    logic [4:0]                         c_hour_reg;
    logic [4:0]                         c_day_reg;
    logic [3:0]                         c_month_reg;
    logic [rbtd_pkg::YOFF_W-1:0]        c_yoff_reg;
    logic                               cache_wr;

    rbtd_pkg::clock_time_t dec_tm;
    logic                  dec_good;
    rbtd_pkg::clock_time_t cache_tm;
    logic [31:0]           elapsed;
    logic                  in_window;
    logic [11:0]           yoff_full;

    logic                   ep_valid;
    rbtd_pkg::read_result_t ep_res;

    rbtd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_now_reg   <= now_ms;
            s0_force_reg <= force_refresh;
            s0_bus_reg   <= bus_ok;
            s0_sec_reg   <= raw_seconds;
            s0_min_reg   <= raw_minutes;
            s0_hour_reg  <= raw_hours;
            s0_date_reg  <= raw_date;
            s0_month_reg <= raw_month;
            s0_year_reg  <= raw_year;
            s1_res_reg   <= s1_res_next;
        end
    end

    rbtd_decode u_decode (
        .raw_seconds (s0_sec_reg),
        .raw_minutes (s0_min_reg),
        .raw_hours   (s0_hour_reg),
        .raw_date    (s0_date_reg),
        .raw_month   (s0_month_reg),
        .raw_year    (s0_year_reg),
        .tm          (dec_tm),
        .valid_time  (dec_good)
    );

    // cached time as delivered; year is kept as an offset from 2024
    always_comb
    begin
        cache_tm.year   = rbtd_pkg::YEAR_BASE + {4'b0, c_yoff_reg};
        cache_tm.month  = c_month_reg;
        cache_tm.day    = c_day_reg;
        cache_tm.hour   = c_hour_reg;
        cache_tm.minute = c_min_reg;
        cache_tm.second = c_sec_reg;
    end

    // poll window: timestamp difference wraps, zero last-poll means never polled
    assign elapsed   = s0_now_reg - last_poll_reg;
    assign in_window = !s0_force_reg && (last_poll_reg != 32'd0)
                     && (elapsed < {8'b0, cfg.poll_interval_ms}) && cache_valid_reg;

    always_comb
    begin
        s1_res_next = '0;
        cache_wr    = 1'b0;
        if (!cfg.device_present)
        begin
            s1_res_next = '0;
        end
        else if (in_window || !s0_bus_reg || !dec_good)
        begin
            // fall back to the cache, or fail if it was never filled
            if (cache_valid_reg)
            begin
                s1_res_next.ok         = 1'b1;
                s1_res_next.from_cache = 1'b1;
                s1_res_next.tm         = cache_tm;
            end
        end
        else
        begin
            s1_res_next.ok         = 1'b1;
            s1_res_next.from_cache = 1'b0;
            s1_res_next.tm         = dec_tm;
            cache_wr               = 1'b1;
        end
    end

    assign yoff_full = dec_tm.year - rbtd_pkg::YEAR_BASE;

    always_comb
    begin
        cache_valid_next = cache_valid_reg;
        last_poll_next   = last_poll_reg;
        if (adv && s0_valid_reg && cache_wr)
        begin
            cache_valid_next = 1'b1;
            last_poll_next   = s0_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg <= 1'b0;
            last_poll_reg   <= 32'd0;
        end
        else
        begin
            cache_valid_reg <= cache_valid_next;
            last_poll_reg   <= last_poll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s0_valid_reg && cache_wr)
        begin
            c_sec_reg   <= dec_tm.second;
            c_min_reg   <= dec_tm.minute;
            c_hour_reg  <= dec_tm.hour;
            c_day_reg   <= dec_tm.day;
            c_month_reg <= dec_tm.month;
            c_yoff_reg  <= yoff_full[rbtd_pkg::YOFF_W-1:0];
        end
    end

    rbtd_epoch u_epoch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .in_res    (s1_res_reg),
        .out_valid (ep_valid),
        .out_res   (ep_res),
        .out_epoch (epoch_seconds)
    );

    assign out_valid  = ep_valid;
    assign read_ok    = ep_res.ok;
    assign from_cache = ep_res.from_cache;
    assign second     = ep_res.tm.second;
    assign minute     = ep_res.tm.minute;
    assign hour       = ep_res.tm.hour;
    assign day        = ep_res.tm.day;
    assign month      = ep_res.tm.month;
    assign year       = ep_res.tm.year;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the RTC BCD time decode and cache unit.
`timescale 1ns / 100ps

module tb_top;

    // ------------------------------------------------------------------
    // One request: a timestamp, the force and bus-ok flags and the seconds, minutes, hours, date, month and year bytes
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [31:0] now_ms;
        logic        force_refresh;
        logic        bus_ok;
        logic [7:0]  raw_seconds;
        logic [7:0]  raw_minutes;
        logic [7:0]  raw_hours;
        logic [7:0]  raw_date;
        logic [7:0]  raw_month;
        logic [7:0]  raw_year;
    } rtc_read_t;

    // One result: status, the delivered time and its epoch seconds
    typedef struct packed {
        rbtd_pkg::read_result_t res;
        logic [31:0]            epoch;
    } time_report_t;

    // Ways in which a well-formed request is spoilt for the near-miss stimulus
    typedef enum int unsigned {
        BREAK_SECOND,
        BREAK_MINUTE,
        BREAK_HOUR,
        BREAK_DATE,
        BREAK_MONTH,
        BREAK_YEAR,
        BREAK_BUS
    } flaw_t;

    // leap years in 1..1969, so that the leap count starts at the epoch
    localparam int unsigned LEAPS_TO_1969 = 477;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [rbtd_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [rbtd_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [rbtd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    logic                in_valid  = 1'b0;
    logic                in_ready;
    rtc_read_t           cur_read  = '0;
    logic [31:0]         now_ms;
    logic                force_refresh;
    logic                bus_ok;
    logic [7:0]          raw_seconds;
    logic [7:0]          raw_minutes;
    logic [7:0]          raw_hours;
    logic [7:0]          raw_date;
    logic [7:0]          raw_month;
    logic [7:0]          raw_year;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                read_ok;
    logic                from_cache;
    logic [5:0]          second;
    logic [5:0]          minute;
    logic [4:0]          hour;
    logic [4:0]          day;
    logic [3:0]          month;
    logic [11:0]         year;
    logic [31:0]         epoch_seconds;

    // the payload ports follow the request register of the driver
    assign now_ms        = cur_read.now_ms;
    assign force_refresh = cur_read.force_refresh;
    assign bus_ok        = cur_read.bus_ok;
    assign raw_seconds   = cur_read.raw_seconds;
    assign raw_minutes   = cur_read.raw_minutes;
    assign raw_hours     = cur_read.raw_hours;
    assign raw_date      = cur_read.raw_date;
    assign raw_month     = cur_read.raw_month;
    assign raw_year      = cur_read.raw_year;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rtc_bcd_time_decode_cache_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .force_refresh (force_refresh),
        .bus_ok        (bus_ok),
        .raw_seconds   (raw_seconds),
        .raw_minutes   (raw_minutes),
        .raw_hours     (raw_hours),
        .raw_date      (raw_date),
        .raw_month     (raw_month),
        .raw_year      (raw_year),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_ok       (read_ok),
        .from_cache    (from_cache),
        .second        (second),
        .minute        (minute),
        .hour          (hour),
        .day           (day),
        .month         (month),
        .year          (year),
        .epoch_seconds (epoch_seconds)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    rtc_read_t    queued_reads [$];    // requests waiting for the driver
    time_report_t expected_times [$];  // predictions, oldest first
    time_report_t oldest_time;

    int unsigned  reads_issued   = 0;
    int unsigned  reads_accepted = 0;
    int unsigned  times_checked  = 0;
    int unsigned  errors         = 0;
    int unsigned  send_idle      = 24;  // per cent of cycles the sender holds back
    int unsigned  recv_idle      = 74;  // per cent of cycles the receiver stalls
    logic         req_taken      = 1'b0;
    logic [31:0]  clock_ms       = 32'd0;

    // shadow of the configuration and of the cache, as left by every accepted request
    rbtd_pkg::cfg_t        cfg = '{device_present: 1'b0,
                                   poll_interval_ms: rbtd_pkg::POLL_RESET};
    rbtd_pkg::clock_time_t cached_tm;
    logic                  cache_valid  = 1'b0;
    logic [31:0]           last_poll_ms = 32'd0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // packed BCD pair, decoded arithmetically: digits above nine pass
    function automatic int unsigned pair_value(logic [7:0] b);
        return b[7:4] * 10 + b[3:0];
    endfunction

    // seconds since 1970 by counting whole years, leap days and month starts;
    // an overflowing day simply runs on into the next month
    function automatic logic [31:0] unix_seconds(rbtd_pkg::clock_time_t t);
        longint unsigned y;
        longint unsigned days;
        longint unsigned mstart;
        y = t.year;
        case (t.month)
            4'd1:    mstart = 0;
            4'd2:    mstart = 31;
            4'd3:    mstart = 59;
            4'd4:    mstart = 90;
            4'd5:    mstart = 120;
            4'd6:    mstart = 151;
            4'd7:    mstart = 181;
            4'd8:    mstart = 212;
            4'd9:    mstart = 243;
            4'd10:   mstart = 273;
            4'd11:   mstart = 304;
            default: mstart = 334;
        endcase
        days = 365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
             - LEAPS_TO_1969 + mstart + t.day - 1;
        if (t.month > 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
            days = days + 1;
        return 32'(days * 86400 + t.hour * 3600 + t.minute * 60 + t.second);
    endfunction

    function automatic time_report_t cache_or_fail();
        time_report_t r;
        r = '0;
        if (cache_valid)
        begin
            r.res.ok         = 1'b1;
            r.res.from_cache = 1'b1;
            r.res.tm         = cached_tm;
            r.epoch          = unix_seconds(cached_tm);
        end
        return r;
    endfunction

    // result of one accepted request; updates the shadow cache on a good read
    function automatic time_report_t decode_time_read(rtc_read_t rq);
        time_report_t          r;
        rbtd_pkg::clock_time_t t;
        int unsigned           s, mi, h, d, mo, y;
        logic [31:0]           since_poll;
        r = '0;
        since_poll = rq.now_ms - last_poll_ms;
        if (!cfg.device_present)
            return r;
        if (!rq.force_refresh && last_poll_ms != 32'd0 &&
            since_poll < {8'd0, cfg.poll_interval_ms} && cache_valid)
            return cache_or_fail();
        if (!rq.bus_ok)
            return cache_or_fail();

        s  = pair_value({1'b0, rq.raw_seconds[6:0]});
        mi = pair_value({1'b0, rq.raw_minutes[6:0]});
        if (rq.raw_hours[6])
        begin
            // 12-hour mode: twelve o'clock is hour zero, PM adds twelve
            h = pair_value({3'b0, rq.raw_hours[4:0]});
            if (h == 12)
                h = 0;
            if (rq.raw_hours[5])
                h = h + 12;
        end
        else
        begin
            h = pair_value({2'b0, rq.raw_hours[5:0]});
        end
        d  = pair_value({2'b0, rq.raw_date[5:0]});
        mo = pair_value({1'b0, rq.raw_month[6:0]});
        y  = (rq.raw_month[7] ? 1900 : 2000) + pair_value(rq.raw_year);

        if (y < 2024 || mo < 1 || mo > 12 || d < 1 || d > 31 ||
            h > 23 || mi > 59 || s > 59)
            return cache_or_fail();

        t.second = s[5:0];
        t.minute = mi[5:0];
        t.hour   = h[4:0];
        t.day    = d[4:0];
        t.month  = mo[3:0];
        t.year   = y[11:0];
        cached_tm    = t;
        cache_valid  = 1'b1;
        last_poll_ms = rq.now_ms;
        r.res.ok     = 1'b1;
        r.res.tm     = t;
        r.epoch      = unix_seconds(t);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // BCD encode; now and then a digit above nine that decodes to the same value
    function automatic logic [7:0] to_bcd(int unsigned v);
        int unsigned hi, lo;
        hi = v / 10;
        lo = v % 10;
        if (hi != 0 && lo < 6 && $urandom_range(9) == 0)
        begin
            hi = hi - 1;
            lo = lo + 10;
        end
        return {hi[3:0], lo[3:0]};
    endfunction

    // random request: mostly well-formed times, some near misses, some noise
    function automatic rtc_read_t make_read();
        rtc_read_t   rq;
        int unsigned pick;
        int unsigned yr_pick;
        int unsigned mon;
        flaw_t       flaw;

        // the millisecond clock moves in steps of the order of the poll window
        if ($urandom_range(7) == 0)
            clock_ms = clock_ms + $urandom;
        else
            clock_ms = clock_ms + $urandom_range(2 * cfg.poll_interval_ms + 8);
        rq.now_ms        = ($urandom_range(49) == 0) ? 32'd0 : clock_ms;
        rq.force_refresh = ($urandom_range(4) == 0);
        rq.bus_ok        = ($urandom_range(19) != 0);

        pick = $urandom_range(99);
        if (pick < 10)
        begin
            rq.bus_ok      = 1'($urandom);
            rq.raw_seconds = 8'($urandom);
            rq.raw_minutes = 8'($urandom);
            rq.raw_hours   = 8'($urandom);
            rq.raw_date    = 8'($urandom);
            rq.raw_month   = 8'($urandom);
            rq.raw_year    = 8'($urandom);
            return rq;
        end

        rq.raw_seconds = {1'($urandom), 7'(to_bcd($urandom_range(59)))};
        rq.raw_minutes = {1'($urandom), 7'(to_bcd($urandom_range(59)))};
        if ($urandom_range(1) == 1)
            rq.raw_hours = {1'($urandom), 1'b1, 1'($urandom),
                            5'(to_bcd($urandom_range(12, 1)))};
        else
            rq.raw_hours = {1'($urandom), 1'b0, 6'(to_bcd($urandom_range(23)))};
        rq.raw_date = {2'($urandom), 6'(to_bcd($urandom_range(31, 1)))};
        mon = $urandom_range(12, 1);
        yr_pick = $urandom_range(9);
        if (yr_pick == 0)
        begin
            // 19xx with a year pair of 120 and up, so mostly at 2024 or later
            rq.raw_month = {1'b1, 7'(to_bcd(mon))};
            rq.raw_year  = {4'($urandom_range(15, 12)), 4'($urandom)};
        end
        else if (yr_pick < 3)
        begin
            rq.raw_month = {1'b0, 7'(to_bcd(mon))};
            rq.raw_year  = {4'($urandom_range(15, 10)), 4'($urandom)};
        end
        else
        begin
            rq.raw_month = {1'b0, 7'(to_bcd(mon))};
            rq.raw_year  = to_bcd($urandom_range(99, 24));
        end

        if (pick < 25)
        begin
            flaw = flaw_t'($urandom_range(BREAK_BUS));
            case (flaw)
                BREAK_SECOND: rq.raw_seconds[6:0] = 7'(to_bcd($urandom_range(79, 60)));
                BREAK_MINUTE: rq.raw_minutes[6:0] = 7'(to_bcd($urandom_range(79, 60)));
                BREAK_HOUR:   rq.raw_hours = {1'($urandom), 1'b0,
                                              6'(to_bcd($urandom_range(39, 24)))};
                BREAK_DATE:   rq.raw_date[5:0] = ($urandom_range(1) == 1) ? 6'h00 :
                                                 6'(to_bcd($urandom_range(39, 32)));
                BREAK_MONTH:  rq.raw_month[6:0] = ($urandom_range(1) == 1) ? 7'h00 :
                                                  7'(to_bcd($urandom_range(19, 13)));
                BREAK_YEAR:
                begin
                    rq.raw_month[7] = 1'($urandom);
                    rq.raw_year = rq.raw_month[7] ? 8'h99 : to_bcd($urandom_range(23));
                end
                default:      rq.bus_ok = 1'b0;
            endcase
        end
        return rq;
    endfunction

    task automatic push_read(rtc_read_t rq);
        queued_reads.push_back(rq);
        reads_issued++;
    endtask

    task automatic random_reads(int unsigned n);
        repeat (n)
            push_read(make_read());
    endtask

    // block idle: every request taken and every result back; counters are
    // only moved at the rising edge, so the falling edge sees them settled
    task automatic settle();
        do
            @(negedge clk);
        while (!(reads_accepted == reads_issued && times_checked == reads_accepted));
    endtask

    // APB write followed by a read-back of the same register
    task automatic program_reg(rbtd_pkg::reg_idx_t idx, logic [31:0] value);
        logic [31:0] stored;
        stored = (idx == rbtd_pkg::REG_DEVICE_PRESENT) ? {31'd0, value[0]}
                                                       : {8'd0, value[23:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", stored, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == rbtd_pkg::REG_DEVICE_PRESENT)
            cfg.device_present = value[0];
        else
            cfg.poll_interval_ms = value[23:0];
    endtask

    // ------------------------------------------------------------------
    // Driver: a new request goes out at the falling edge once the last one
    // has been taken; valid holds, payload unchanged, until accepted
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || req_taken)
            begin
                if (queued_reads.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_read <= queued_reads.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted request, checks every result
    // against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                expected_times.push_back(decode_time_read(cur_read));
                reads_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_times.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    oldest_time = expected_times.pop_front();
                    check_field("read_ok",       oldest_time.res.ok,         read_ok);
                    check_field("from_cache",    oldest_time.res.from_cache, from_cache);
                    check_field("second",        oldest_time.res.tm.second,  second);
                    check_field("minute",        oldest_time.res.tm.minute,  minute);
                    check_field("hour",          oldest_time.res.tm.hour,    hour);
                    check_field("day",           oldest_time.res.tm.day,     day);
                    check_field("month",         oldest_time.res.tm.month,   month);
                    check_field("year",          oldest_time.res.tm.year,    year);
                    check_field("epoch_seconds", oldest_time.epoch,          epoch_seconds);
                    times_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // device still absent after reset: every read fails with zeros
        push_read('{32'd50, 1'b0, 1'b1, 8'h30, 8'h45, 8'h10, 8'h15, 8'h06, 8'h25});
        push_read('{32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        settle();
        // poll window left at its reset value for the directed requests
        program_reg(rbtd_pkg::REG_DEVICE_PRESENT, 32'd1);

        // no cache yet: bus failure and a year before 2024 both fail
        push_read('{32'd100, 1'b0, 1'b0, 8'h30, 8'h45, 8'h10, 8'h15, 8'h06, 8'h25});
        push_read('{32'd110, 1'b0, 1'b1, 8'h30, 8'h45, 8'h10, 8'h15, 8'h06, 8'h23});
        // good read at time zero leaves the block looking never polled
        push_read('{32'd0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24});
        push_read('{32'd5, 1'b0, 1'b1, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99});
        // inside the window, not forced: cached time
        push_read('{32'd20, 1'b0, 1'b1, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h30});
        // 12-hour mode: midnight, noon, 11 PM, then 13 PM which is out of range
        push_read('{32'd40, 1'b1, 1'b1, 8'h05, 8'h10, 8'h52, 8'h09, 8'h03, 8'h26});
        push_read('{32'd60, 1'b1, 1'b1, 8'h05, 8'h10, 8'h72, 8'h09, 8'h03, 8'h26});
        push_read('{32'd70, 1'b1, 1'b1, 8'h05, 8'h10, 8'h71, 8'h09, 8'h03, 8'h26});
        push_read('{32'd80, 1'b1, 1'b1, 8'h05, 8'h10, 8'h73, 8'h09, 8'h03, 8'h26});
        // bus failure and a bad second with a cache present
        push_read('{32'd90, 1'b1, 1'b0, 8'h05, 8'h10, 8'h10, 8'h09, 8'h03, 8'h26});
        push_read('{32'd100, 1'b1, 1'b1, 8'h60, 8'h10, 8'h10, 8'h09, 8'h03, 8'h26});
        // century flag: 1900 + 159 passes, 1999 does not
        push_read('{32'd120, 1'b1, 1'b1, 8'h15, 8'h20, 8'h08, 8'h14, 8'h81, 8'hF9});
        push_read('{32'd130, 1'b1, 1'b1, 8'h15, 8'h20, 8'h08, 8'h14, 8'h85, 8'h99});
        // digits above nine everywhere, year 2165 so the epoch wraps
        push_read('{32'd140, 1'b1, 1'b1, 8'h1F, 8'h4F, 8'h1D, 8'h1F, 8'h0C, 8'hFF});
        // 31 February of a leap year rolls into March
        push_read('{32'd160, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h24});
        // out of range month, day and hour, and an all-zero read
        push_read('{32'd180, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h10, 8'h13, 8'h24});
        push_read('{32'd190, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h24});
        push_read('{32'd200, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h32, 8'h05, 8'h24});
        push_read('{32'd210, 1'b1, 1'b1, 8'h00, 8'h00, 8'h24, 8'h10, 8'h05, 8'h24});
        push_read('{32'd220, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        // window measured across the wrap of the millisecond counter
        push_read('{32'hFFFF_FF00, 1'b1, 1'b1, 8'h42, 8'h17, 8'h19, 8'h28, 8'h11, 8'h40});
        push_read('{32'h0000_0010, 1'b0, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h41});
        push_read('{32'h0000_0400, 1'b0, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h41});
        // ignored upper bits set on an otherwise good read, hour in 12-hour mode
        push_read('{32'h0000_0500, 1'b1, 1'b1, 8'hD9, 8'hA0, 8'hC1, 8'hC5, 8'h07, 8'h30});
        settle();

        // zero window: the cache only serves failed reads
        program_reg(rbtd_pkg::REG_POLL_INTERVAL, 32'd0);
        random_reads(200);
        settle();

        // widest window, written with junk in the unused upper byte
        program_reg(rbtd_pkg::REG_POLL_INTERVAL, 32'hFFFF_FFFF);
        random_reads(200);
        settle();

        send_idle = 74;
        recv_idle = 24;
        program_reg(rbtd_pkg::REG_DEVICE_PRESENT, 32'd0);
        program_reg(rbtd_pkg::REG_POLL_INTERVAL, $urandom_range(5000, 1));
        random_reads(100);
        settle();

        program_reg(rbtd_pkg::REG_DEVICE_PRESENT, 32'd1);
        random_reads(250);
        settle();

        // both sides at full rate
        send_idle = 0;
        recv_idle = 0;
        program_reg(rbtd_pkg::REG_POLL_INTERVAL, 32'd1);
        random_reads(250);
        settle();

        program_reg(rbtd_pkg::REG_POLL_INTERVAL, 32'd1000);
        random_reads(250);
        settle();

        // allow for the pipeline depth in case anything stray comes out
        repeat (8) @(posedge clk);
        if (expected_times.size() != 0)
        begin
            $error("%0d results never arrived", expected_times.size());
            errors++;
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
